FILE: design/lea_pkg.sv
`timescale 1ns / 1ps

package lea_pkg;

   localparam int MAX_ROUNDS     = 32;
   localparam int KEYS_PER_ROUND = 6;
   localparam int RND_W          = $clog2(MAX_ROUNDS);

   // Key size codes.
   localparam logic [1:0] KS_128 = 2'd0;
   localparam logic [1:0] KS_192 = 2'd1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_KEY_SIZE = 3'd0;
   localparam logic [2:0] CSR_KEY_0    = 3'd1;
   localparam logic [2:0] CSR_KEY_1    = 3'd2;
   localparam logic [2:0] CSR_KEY_2    = 3'd3;
   localparam logic [2:0] CSR_KEY_3    = 3'd4;

   localparam logic [31:0] DELTA [8] = '{
      32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
      32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
   };

   // Rotation applied to each key word in the schedule.
   localparam logic [4:0] KS_ROT [6] = '{5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17};

   typedef struct packed {
      logic        op;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   typedef logic [KEYS_PER_ROUND-1:0][31:0] rk_row_type;
   typedef rk_row_type [MAX_ROUNDS-1:0]     rk_bank_type;
   typedef logic [3:0][31:0]                blk_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] amt);
      logic [63:0] w;
      w = {x, x} << amt;
      return w[63:32];
   endfunction

   // One encryption round.
   function automatic blk_type enc_round(input blk_type x, input rk_row_type k);
      blk_type n;
      n[0] = rotl32((x[0] ^ k[0]) + (x[1] ^ k[1]), 5'd9);
      n[1] = rotl32((x[1] ^ k[2]) + (x[2] ^ k[3]), 5'd27);
      n[2] = rotl32((x[2] ^ k[4]) + (x[3] ^ k[5]), 5'd29);
      n[3] = x[0];
      return n;
   endfunction

   // One decryption round, the inverse of enc_round.
   function automatic blk_type dec_round(input blk_type x, input rk_row_type k);
      blk_type n;
      n[0] = x[3];
      n[1] = (rotl32(x[0], 5'd23) - (n[0] ^ k[0])) ^ k[1];
      n[2] = (rotl32(x[1], 5'd5) - (n[1] ^ k[2])) ^ k[3];
      n[3] = (rotl32(x[2], 5'd3) - (n[2] ^ k[4])) ^ k[5];
      return n;
   endfunction

endpackage

FILE: design/lea_key_sched.sv
`timescale 1ns / 1ps

module lea_key_sched import lea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output logic [1:0]  key_size,
   output logic        keys_ready,
   output rk_bank_type rk_bank
);

   typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DONE} state_type;

   state_type         state_ff;
   logic [1:0]        key_size_ff;
   logic [3:0][63:0]  key_ff;
   logic [7:0][31:0]  t_ff, t_in;
   logic [RND_W-1:0]  rnd_ff, last_rnd;
   logic [2:0]        d6_ff;
   rk_bank_type       rk_ff;
   rk_row_type        row_in;

   // Last round index for the selected key size.
   always_comb begin
      case (key_size_ff)
         KS_128:  last_rnd = RND_W'(23);
         KS_192:  last_rnd = RND_W'(27);
         default: last_rnd = RND_W'(MAX_ROUNDS - 1);
      endcase
   end

   // One schedule round: every updated word is independent of the others.
   always_comb begin
      logic [31:0] d;
      logic [2:0]  base;
      logic [2:0]  k;
      t_in   = t_ff;
      row_in = '0;
      d      = '0;
      k      = '0;
      base   = {rnd_ff[1:0], 1'b0} + {rnd_ff[0], 2'b00};
      case (key_size_ff)
         KS_128: begin
            d = DELTA[{1'b0, rnd_ff[1:0]}];
            for (int j = 0; j < 4; j++) begin
               t_in[j] = rotl32(t_ff[j] + rotl32(d, rnd_ff + RND_W'(j)), KS_ROT[j]);
            end
            row_in = {t_in[1], t_in[3], t_in[1], t_in[2], t_in[1], t_in[0]};
         end
         KS_192: begin
            d = DELTA[d6_ff];
            for (int j = 0; j < 6; j++) begin
               t_in[j]   = rotl32(t_ff[j] + rotl32(d, rnd_ff + RND_W'(j)), KS_ROT[j]);
               row_in[j] = t_in[j];
            end
         end
         default: begin
            d = DELTA[rnd_ff[2:0]];
            for (int j = 0; j < 6; j++) begin
               k         = base + 3'(j);
               t_in[k]   = rotl32(t_ff[k] + rotl32(d, rnd_ff + RND_W'(j)), KS_ROT[j]);
               row_in[j] = t_in[k];
            end
         end
      endcase
   end

   // Register writes, expansion sequencer and round key store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         key_size_ff <= '0;
         key_ff      <= '0;
         rnd_ff      <= '0;
         d6_ff       <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_SIZE: begin
               key_size_ff <= csr_data[1:0];
               state_ff    <= ST_LOAD;
            end
            CSR_KEY_0, CSR_KEY_1, CSR_KEY_2, CSR_KEY_3: begin
               key_ff[2'(csr_index - CSR_KEY_0)] <= csr_data;
               state_ff                          <= ST_LOAD;
            end
            default: ;
         endcase
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               t_ff     <= key_ff;
               rnd_ff   <= '0;
               d6_ff    <= '0;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               t_ff          <= t_in;
               rk_ff[rnd_ff] <= row_in;
               rnd_ff        <= rnd_ff + 1'b1;
               d6_ff         <= (d6_ff == 3'd5) ? 3'd0 : d6_ff + 3'd1;
               if (rnd_ff == last_rnd) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: ;
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign key_size   = key_size_ff;
   assign keys_ready = (state_ff == ST_DONE);
   assign rk_bank    = rk_ff;

endmodule

FILE: design/lea_round_pipe.sv
`timescale 1ns / 1ps

module lea_round_pipe import lea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  req_type     in_data,
   output logic        in_ready,
   input  logic [1:0]  key_size,
   input  rk_bank_type rk_bank,
   output logic        out_valid,
   output rsp_type     out_data,
   input  logic        out_ready
);

   typedef struct packed {
      logic    op;
      blk_type x;
   } stage_type;

   logic [MAX_ROUNDS-1:0] vld_ff;
   stage_type             st_ff [MAX_ROUNDS];
   stage_type             st_in [MAX_ROUNDS];
   logic [RND_W:0]        enc_end, dec_start;
   logic                  adv;

   // Encryption uses the first rounds, decryption the last ones.
   always_comb begin
      case (key_size)
         KS_128:  enc_end = (RND_W+1)'(24);
         KS_192:  enc_end = (RND_W+1)'(28);
         default: enc_end = (RND_W+1)'(MAX_ROUNDS);
      endcase
      dec_start = (RND_W+1)'(MAX_ROUNDS) - enc_end;
   end

   // Whole pipeline moves when its last stage is free or being drained.
   assign adv = !vld_ff[MAX_ROUNDS-1] || out_ready;

   // Each stage does one round, or passes the block when its round is unused.
   always_comb begin
      stage_type src;
      logic      act;
      for (int s = 0; s < MAX_ROUNDS; s++) begin
         if (s == 0) begin
            src.op = in_data.op;
            src.x  = {in_data.block_high, in_data.block_low};
         end else begin
            src = st_ff[s-1];
         end
         act = src.op ? ((RND_W+1)'(s) >= dec_start) : ((RND_W+1)'(s) < enc_end);
         st_in[s] = src;
         if (act) begin
            st_in[s].x = src.op ? dec_round(src.x, rk_bank[MAX_ROUNDS-1-s])
                                : enc_round(src.x, rk_bank[s]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[MAX_ROUNDS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < MAX_ROUNDS; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign in_ready  = adv;
   assign out_valid = vld_ff[MAX_ROUNDS-1];
   assign out_data  = {st_ff[MAX_ROUNDS-1].x[3], st_ff[MAX_ROUNDS-1].x[2],
                       st_ff[MAX_ROUNDS-1].x[1], st_ff[MAX_ROUNDS-1].x[0]};

endmodule

FILE: design/lea_block_cipher.sv
`timescale 1ns / 1ps

// LEA block cipher with 128, 192 or 256-bit keys. Requests pass through a
// 32-stage round pipeline, one round per stage, so a new request is taken every
// cycle while the keys are ready and the output is not stalled (unused rounds of
// shorter keys are passed through). Round keys are expanded one round per cycle
// by the key schedule: after reset and after a write to the key size or key
// registers, requests are held off while the key store is refilled.
module lea_block_cipher import lea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic        keys_ready;
   logic [1:0]  key_size;
   rk_bank_type rk_bank;
   logic        pipe_ready;

   assign csr_ready = 1'b1;

   lea_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .key_size   (key_size),
      .keys_ready (keys_ready),
      .rk_bank    (rk_bank)
   );

   lea_round_pipe u_round_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid && keys_ready),
      .in_data   (req_data),
      .in_ready  (pipe_ready),
      .key_size  (key_size),
      .rk_bank   (rk_bank),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (rsp_ready)
   );

   // Requests are only taken once the key store is complete.
   assign req_ready = pipe_ready && keys_ready;

`ifndef ASSERT_OFF
   // A request is never taken against a partly written key store.
   a_req_keys: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> keys_ready)
      else $error("request accepted while keys not ready");

   // A write to the key size or a key register always starts a new key expansion.
   a_csr_rekey: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index <= CSR_KEY_3) |=> !keys_ready)
      else $error("register write did not restart key expansion");

   // Keys cannot be ready in the cycle after reset.
   a_reset_keys: assert property (@(posedge clock)
      reset |=> !keys_ready)
      else $error("keys ready right after reset");
`endif

endmodule

FILE: tb/lea_checker.sv
`timescale 1ns / 1ps

module lea_checker import lea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   logic [1:0]  key_code;
   logic [63:0] key_word [4];
   logic [31:0] sched [MAX_ROUNDS*KEYS_PER_ROUND];
   rsp_type     expected_blocks [$];

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      n = n % 32;
      return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
   endfunction

   function automatic int rounds_for_key();
      if (key_code == KS_128) return 24;
      if (key_code == KS_192) return 28;
      return 32;
   endfunction

   // Rebuild the round key schedule from the current key registers.
   task automatic rebuild_schedule();
      logic [31:0] t [8];
      logic [31:0] d;
      int k;
      for (int i = 0; i < 4; i++) begin
         t[2*i]   = key_word[i][31:0];
         t[2*i+1] = key_word[i][63:32];
      end
      if (key_code == KS_128) begin
         for (int i = 0; i < 24; i++) begin
            d = DELTA[i % 4];
            for (int j = 0; j < 4; j++) t[j] = rol(t[j] + rol(d, i + j), KS_ROT[j]);
            sched[i*6+0] = t[0];
            sched[i*6+1] = t[1];
            sched[i*6+2] = t[2];
            sched[i*6+3] = t[1];
            sched[i*6+4] = t[3];
            sched[i*6+5] = t[1];
         end
      end else if (key_code == KS_192) begin
         for (int i = 0; i < 28; i++) begin
            d = DELTA[i % 6];
            for (int j = 0; j < 6; j++) begin
               t[j] = rol(t[j] + rol(d, i + j), KS_ROT[j]);
               sched[i*6+j] = t[j];
            end
         end
      end else begin
         for (int i = 0; i < 32; i++) begin
            d = DELTA[i % 8];
            for (int j = 0; j < 6; j++) begin
               k = (6 * i + j) % 8;
               t[k] = rol(t[k] + rol(d, i + j), KS_ROT[j]);
               sched[i*6+j] = t[k];
            end
         end
      end
   endtask

   // Encrypt or decrypt one block with the current schedule.
   function automatic rsp_type cipher_block(input req_type rq);
      logic [31:0] x0, x1, x2, x3, p0, p1, p2;
      int nr, r;
      rsp_type res;
      nr = rounds_for_key();
      x0 = rq.block_low[31:0];
      x1 = rq.block_low[63:32];
      x2 = rq.block_high[31:0];
      x3 = rq.block_high[63:32];
      for (int i = 0; i < nr; i++) begin
         if (rq.op == 1'b0) begin
            p0 = x0;
            x0 = rol((x0 ^ sched[i*6+0]) + (x1 ^ sched[i*6+1]), 9);
            x1 = rol((x1 ^ sched[i*6+2]) + (x2 ^ sched[i*6+3]), 27);
            x2 = rol((x2 ^ sched[i*6+4]) + (x3 ^ sched[i*6+5]), 29);
            x3 = p0;
         end else begin
            r = nr - 1 - i;
            p0 = x0;
            p1 = x1;
            p2 = x2;
            x0 = x3;
            x1 = (rol(p0, 23) - (x0 ^ sched[r*6+0])) ^ sched[r*6+1];
            x2 = (rol(p1, 5) - (x1 ^ sched[r*6+2])) ^ sched[r*6+3];
            x3 = (rol(p2, 3) - (x2 ^ sched[r*6+4])) ^ sched[r*6+5];
         end
      end
      res.result_low  = {x1, x0};
      res.result_high = {x3, x2};
      return res;
   endfunction

   assign pending_count = expected_blocks.size();

   // Track register writes, predict each request and compare each response.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         key_code = KS_128;
         for (int i = 0; i < 4; i++) key_word[i] = '0;
         rebuild_schedule();
         expected_blocks.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_KEY_SIZE) begin
               key_code = csr_data[1:0];
               rebuild_schedule();
            end else if (csr_index <= CSR_KEY_3) begin
               key_word[csr_index - CSR_KEY_0] = csr_data;
               rebuild_schedule();
            end
         end
         if (req_valid && req_ready) expected_blocks.push_back(cipher_block(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_data.result_low !== want.result_low) begin
                  $error("result_low expected %h actual %h", want.result_low,
                         rsp_data.result_low);
                  fail_count++;
               end
               if (rsp_data.result_high !== want.result_high) begin
                  $error("result_high expected %h actual %h", want.result_high,
                         rsp_data.result_high);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lea_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          sent_blocks = 0;
   int          got_blocks = 0;
   int          quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lea_block_cipher u_top (.*);

   lea_checker u_checker (.*);

   // Response side: stall a random number of cycles before each response.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Count handshakes and watch for a stalled run.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sent_blocks++;
         if (rsp_valid && rsp_ready) got_blocks++;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Send one request after a random gap; returns at a falling edge after acceptance.
   task automatic send_block(input logic op, input logic [63:0] lo, input logic [63:0] hi);
      int gap;
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op: op, block_high: hi, block_low: lo};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for every outstanding response, then let the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (got_blocks != sent_blocks) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic load_key(input logic [1:0] code, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
      write_reg(CSR_KEY_0, k0);
      write_reg(CSR_KEY_1, k1);
      write_reg(CSR_KEY_2, k2);
      write_reg(CSR_KEY_3, k3);
      // Upper bits of the size register are don't-care.
      write_reg(CSR_KEY_SIZE, {62'(rand64()), code});
      // A write past the last register must leave everything alone.
      if ($urandom_range(0, 1)) write_reg(3'($urandom_range(5, 7)), rand64());
   endtask

   initial begin
      int count;
      logic [63:0] lo, hi;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset key, then extreme keys and blocks in every key size.
      send_block(1'b0, '0, '0);
      send_block(1'b1, '0, '0);
      drain();
      load_key(KS_128, '1, '1, '1, '1);
      send_block(1'b0, '1, '1);
      send_block(1'b1, '1, '1);
      send_block(1'b0, '0, '1);
      drain();
      write_reg(3'd7, rand64());
      send_block(1'b1, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
      drain();
      load_key(KS_192, '0, '1, 64'h0123_4567_89ab_cdef, '0);
      send_block(1'b0, '0, '0);
      send_block(1'b1, '1, '1);
      drain();
      load_key(2'd2, '1, '0, '1, '0);
      send_block(1'b0, '1, '0);
      send_block(1'b1, '0, '1);
      drain();
      load_key(2'd3, rand64(), rand64(), rand64(), rand64());
      send_block(1'b0, rand64(), rand64());
      send_block(1'b1, rand64(), rand64());
      drain();

      // Random phases, each under a fresh key.
      for (int phase = 0; phase < 10; phase++) begin
         load_key(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
         count = $urandom_range(50, 100);
         for (int n = 0; n < count; n++) begin
            lo = rand64();
            hi = rand64();
            case ($urandom_range(0, 9))
               0: lo = '0;
               1: hi = '1;
               default: ;
            endcase
            send_block(1'($urandom_range(0, 1)), lo, hi);
            // Runs of back-to-back requests.
            if ($urandom_range(0, 19) == 0)
               repeat ($urandom_range(5, 20)) begin
                  req_valid <= 1'b1;
                  req_data  <= '{op: 1'($urandom), block_high: rand64(), block_low: rand64()};
                  do @(posedge clock); while (!req_ready);
                  @(negedge clock);
               end
         end
         drain();
      end

      if (fail_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
